/* rtl/pfla_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pfla_pkg;

    localparam int unsigned SLOT_FIELD_W = 10;
    localparam int unsigned COUNT_FIELD_W = 11;
    localparam int unsigned MARGIN_W = 11;

    localparam logic [MARGIN_W-1:0] MARGIN_RESET = 11'd32;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    typedef struct packed {
        logic                    cmd;
        logic [SLOT_FIELD_W-1:0] release_slot;
    } t_cmd_in;

    typedef struct packed {
        logic [SLOT_FIELD_W-1:0]  granted_slot;
        logic                     ok;
        logic                     collect_soon;
        logic [COUNT_FIELD_W-1:0] in_use;
    } t_result;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

endpackage

`default_nettype wire

/* rtl/pfla_link_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module pfla_link_ram #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned WIDTH = 11
) (
    input  wire                      i_clk,
    input  wire                      i_wr_en,
    input  wire  [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire  [WIDTH-1:0]         i_wr_data,
    input  wire  [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* rtl/pool_free_list_allocator_core.sv */
// A command taken while idle is latched into r_cmd, executed in the execute state,
// and its result is registered and strobed on o_done.
// No new command is taken while busy; the link memory read of the list head
// must complete before the next pop. The receiver cannot stall results.
// Reset (synchronous, active low) empties the free list, clears the counters and
// the collect-soon flag and restores the margin; the link memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module pool_free_list_allocator_core
    import pfla_pkg::*;
#(
    parameter int unsigned POOL_DEPTH = 1024
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 start,
    output logic                busy,
    input  wire  t_cmd_in       i_cmd,
    output logic                o_done,
    output t_result             o_result,
    input  wire                 i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire  [MARGIN_W-1:0] i_cfg_data
);

    localparam int unsigned SLOT_W = $clog2(POOL_DEPTH);
    localparam int unsigned CNT_W = $clog2(POOL_DEPTH + 1);
    localparam int unsigned CMP_W = ((CNT_W > MARGIN_W) ? CNT_W : MARGIN_W) + 1;
    localparam int unsigned LINK_W = SLOT_W + 1;
    localparam logic [SLOT_W-1:0] HW_LIMIT = SLOT_W'(POOL_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(POOL_DEPTH);
    localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(POOL_DEPTH);

    t_state              r_state, n_state;
    t_cmd_in             r_cmd;
    logic [SLOT_W-1:0]   r_head, n_head;
    logic                r_nonempty, n_nonempty;
    logic [SLOT_W-1:0]   r_hw, n_hw;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_flag, n_flag;
    logic [MARGIN_W-1:0] r_margin;
    logic                r_done, n_done;
    t_result             r_result, n_result;

    logic                wr_en;
    logic [SLOT_W-1:0]   rel_idx;
    logic                rel_in_range;
    logic [LINK_W-1:0]   rd_link;
    logic [CMP_W-1:0]    free_slots;

    // The head entry is read at every edge; in the execute cycle it holds the link
    // of the head as it stood when the command was taken. Writes happen only in
    // the execute cycle, and the read taken at the edge that ends it is never used.
    pfla_link_ram #(
        .DEPTH (POOL_DEPTH),
        .WIDTH (LINK_W)
    ) u_link_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (rel_idx),
        .i_wr_data ({r_nonempty, r_head}),
        .i_rd_addr (r_head),
        .o_rd_data (rd_link)
    );

    assign rel_idx = SLOT_W'(r_cmd.release_slot);
    assign rel_in_range = (32'(r_cmd.release_slot) < POOL_DEPTH);

    always_comb begin
        n_state = r_state;
        n_head = r_head;
        n_nonempty = r_nonempty;
        n_hw = r_hw;
        n_count = r_count;
        n_flag = r_flag;
        n_done = 1'b0;
        n_result = r_result;
        wr_en = 1'b0;
        free_slots = DEPTH_CMP;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
                n_done = 1'b1;
                n_result.granted_slot = '0;
                n_result.ok = 1'b0;
                if (r_cmd.cmd == CMD_ALLOC) begin
                    if (r_nonempty) begin
                        n_result.granted_slot = SLOT_FIELD_W'(r_head);
                        n_result.ok = 1'b1;
                        n_head = rd_link[SLOT_W-1:0];
                        n_nonempty = rd_link[SLOT_W];
                    end else if (r_hw < HW_LIMIT) begin
                        n_result.granted_slot = SLOT_FIELD_W'(r_hw);
                        n_result.ok = 1'b1;
                        n_hw = r_hw + 1'b1;
                    end
                    if (n_result.ok) begin
                        if (r_count < CNT_MAX) begin
                            n_count = r_count + 1'b1;
                        end
                        free_slots = DEPTH_CMP - CMP_W'(n_count);
                        if (free_slots < CMP_W'(r_margin)) begin
                            n_flag = 1'b1;
                        end
                    end
                end else begin
                    n_result.granted_slot = r_cmd.release_slot;
                    if (rel_in_range) begin
                        wr_en = 1'b1;
                        n_head = rel_idx;
                        n_nonempty = 1'b1;
                        n_result.ok = 1'b1;
                        if (r_count != '0) begin
                            n_count = r_count - 1'b1;
                        end
                    end
                end
                n_result.collect_soon = n_flag;
                n_result.in_use = COUNT_FIELD_W'(n_count);
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_head <= '0;
            r_nonempty <= 1'b0;
            r_hw <= '0;
            r_count <= '0;
            r_flag <= 1'b0;
            r_margin <= MARGIN_RESET;
            r_done <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head <= n_head;
            r_nonempty <= n_nonempty;
            r_hw <= n_hw;
            r_count <= n_count;
            r_flag <= n_flag;
            r_done <= n_done;
            if (i_cfg_valid) begin
                r_margin <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && start) begin
            r_cmd <= i_cmd;
        end
        r_result <= n_result;
    end

    assign busy = (r_state == ST_EXEC);
    assign o_done = r_done;
    assign o_result = r_result;
    assign o_cfg_ready = 1'b1;

    // A command occupies exactly one execute cycle.
    a_busy_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("busy held for more than one cycle");

    // Every execute cycle yields exactly one result strobe.
    a_done_follows_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (o_done == $past(busy)))
        else $error("result strobe does not follow the execute cycle");

    // The high-water mark only ever steps up by one.
    a_hw_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$stable(r_hw) |-> (r_hw == $past(r_hw) + 1'b1))
        else $error("high-water mark moved by other than one");

    // A failed allocation leaves the pool state untouched.
    a_fail_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_result.ok && (r_cmd.cmd == CMD_ALLOC)
            |-> ($stable(r_count) && $stable(r_hw) && $stable(r_head)))
        else $error("failed allocation changed the pool state");

endmodule

`default_nettype wire

/* test/pool_free_list_allocator_core_tb.sv */
`timescale 1ns / 1ps

module pool_free_list_allocator_core_tb;
    import pfla_pkg::*;

    localparam int unsigned POOL_DEPTH = 1024;
    localparam int unsigned SHOWN_MISMATCHES = 10;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    t_cmd_in             i_cmd;
    logic                o_done;
    t_result             o_result;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [MARGIN_W-1:0] i_cfg_data;

    pool_free_list_allocator_core #(
        .POOL_DEPTH(POOL_DEPTH)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_cmd      (i_cmd),
        .o_done     (o_done),
        .o_result   (o_result),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow copy of the allocator state.
    logic [SLOT_FIELD_W-1:0] link_mem [POOL_DEPTH];
    bit                      link_live [POOL_DEPTH];
    logic [SLOT_FIELD_W-1:0] free_head;
    bit                      free_nonempty;
    int unsigned             high_mark;
    int unsigned             active_slots;
    bit                      collect_flag;
    logic [MARGIN_W-1:0]     margin_reg;

    t_result                 expected_replies [$];
    t_result                 last_reply;
    logic [SLOT_FIELD_W-1:0] held_slots [$];

    int unsigned mismatches;
    int unsigned replies_checked;
    int unsigned sent_count;
    int unsigned grants;
    int unsigned exhausted_replies;
    int unsigned releases;
    int unsigned peak_in_use;
    int unsigned quiet_run;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_result allocator_reply(input t_cmd_in c);
        t_result r;
        r = '0;
        if (c.cmd == CMD_ALLOC) begin
            if (free_nonempty) begin
                // The head is always a valid index, as slots are exactly 10 bits wide.
                r.granted_slot = free_head;
                r.ok = 1'b1;
                free_nonempty = link_live[free_head];
                free_head = link_mem[free_head];
            end else if (high_mark < POOL_DEPTH - 1) begin
                r.granted_slot = high_mark[SLOT_FIELD_W-1:0];
                high_mark++;
                r.ok = 1'b1;
            end
            if (r.ok) begin
                if (active_slots < POOL_DEPTH) active_slots++;
                if (POOL_DEPTH - active_slots < int'(margin_reg)) collect_flag = 1'b1;
            end
        end else begin
            r.granted_slot = c.release_slot;
            r.ok = 1'b1;
            link_mem[c.release_slot] = free_head;
            link_live[c.release_slot] = free_nonempty;
            free_head = c.release_slot;
            free_nonempty = 1'b1;
            if (active_slots > 0) active_slots--;
        end
        r.collect_soon = collect_flag;
        r.in_use = active_slots[COUNT_FIELD_W-1:0];
        return r;
    endfunction

    // Mostly short gaps, a few long ones, and now and then a stretch with none.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (quiet_run > 0) begin
            quiet_run--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            quiet_run = $urandom_range(20, 60);
            return 0;
        end
        if (roll < 50) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 25);
    endfunction

    task automatic send_command(input t_cmd_in c);
        int unsigned gap;
        @(negedge i_clk);
        start <= 1'b1;
        i_cmd <= c;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        last_reply = allocator_reply(c);
        expected_replies.push_back(last_reply);
        sent_count++;
        if (32'(last_reply.in_use) > peak_in_use) peak_in_use = 32'(last_reply.in_use);
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic do_alloc();
        t_cmd_in c;
        c.cmd = CMD_ALLOC;
        // The slot field is ignored here, so it carries noise.
        c.release_slot = SLOT_FIELD_W'($urandom_range(0, POOL_DEPTH - 1));
        send_command(c);
        if (last_reply.ok) begin
            grants++;
            held_slots.push_back(last_reply.granted_slot);
        end else begin
            exhausted_replies++;
        end
    endtask

    task automatic do_release(input logic [SLOT_FIELD_W-1:0] slot);
        t_cmd_in c;
        int      idx [$];
        c.cmd = CMD_RELEASE;
        c.release_slot = slot;
        send_command(c);
        releases++;
        idx = held_slots.find_first_index(s) with (s == slot);
        if (idx.size() > 0) held_slots.delete(idx[0]);
    endtask

    task automatic random_command(input int unsigned alloc_pct);
        if ($urandom_range(0, 99) < alloc_pct) begin
            do_alloc();
        end else if (held_slots.size() > 0 && $urandom_range(0, 99) < 88) begin
            do_release(held_slots[$urandom_range(0, held_slots.size() - 1)]);
        end else begin
            // A random slot, which may be a double release or a slot never handed out.
            do_release(SLOT_FIELD_W'($urandom_range(0, POOL_DEPTH - 1)));
        end
    endtask

    task automatic wait_idle();
        int unsigned guard;
        guard = 0;
        @(negedge i_clk);
        start <= 1'b0;
        while (expected_replies.size() != 0 && guard < 1000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_margin(input logic [MARGIN_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        margin_reg = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Pushes and pops in a known order, releases while nothing is in use, then allocates again.
    task automatic test_list_order();
        do_alloc();
        do_alloc();
        do_release(10'd1);
        do_alloc();
        do_release(10'd0);
        do_release(10'd1);
        do_alloc();
        do_alloc();
        do_alloc();
        do_release(10'd2);
        do_release(10'd1);
        do_release(10'd0);
        // The count is now zero; these releases must not take it below zero.
        do_release(10'd0);
        do_release(10'd1023);
        do_release(10'h2AA);
        do_release(10'h155);
        repeat (6) do_alloc();
        wait_idle();
    endtask

    task automatic test_margin_zero_churn();
        write_margin('0);
        repeat (100) random_command(50);
        wait_idle();
    endtask

    task automatic test_margin_one_churn();
        write_margin(11'd1);
        repeat (100) random_command(55);
        wait_idle();
    endtask

    // Climbs through the flag threshold and into exhaustion.
    task automatic test_fill_to_exhaustion();
        int unsigned guard;
        int unsigned fails_before;
        write_margin(MARGIN_RESET);
        fails_before = exhausted_replies;
        guard = 0;
        while (exhausted_replies < fails_before + 6 && guard < 4000) begin
            random_command(97);
            guard++;
        end
        wait_idle();
    endtask

    task automatic test_exhausted_churn();
        write_margin(11'd1024);
        repeat (60) random_command(50);
        wait_idle();
        write_margin(11'd1023);
        repeat (60) random_command(50);
        wait_idle();
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_done === 1'b1) begin
            replies_checked++;
            if (expected_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOWN_MISMATCHES)
                    $display("Unexpected result: slot %0d ok %b flag %b in_use %0d",
                             o_result.granted_slot, o_result.ok,
                             o_result.collect_soon, o_result.in_use);
            end else begin
                want = expected_replies.pop_front();
                if (o_result.granted_slot !== want.granted_slot || o_result.ok !== want.ok ||
                    o_result.collect_soon !== want.collect_soon ||
                    o_result.in_use !== want.in_use) begin
                    mismatches++;
                    if (mismatches <= SHOWN_MISMATCHES) begin
                        $display("Mismatch on result %0d: expected slot %0d ok %b flag %b %s %0d",
                                 replies_checked, want.granted_slot, want.ok,
                                 want.collect_soon, "in_use", want.in_use);
                        $display("    got slot %0d ok %b flag %b in_use %0d",
                                 o_result.granted_slot, o_result.ok,
                                 o_result.collect_soon, o_result.in_use);
                    end
                end
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cmd = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        free_head = '0;
        free_nonempty = 1'b0;
        high_mark = 0;
        active_slots = 0;
        collect_flag = 1'b0;
        margin_reg = MARGIN_RESET;
        mismatches = 0;
        replies_checked = 0;
        sent_count = 0;
        grants = 0;
        exhausted_replies = 0;
        releases = 0;
        peak_in_use = 0;
        quiet_run = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        test_list_order();
        test_margin_zero_churn();
        test_margin_one_churn();
        test_fill_to_exhaustion();
        test_exhausted_churn();

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (expected_replies.size() != 0) begin
            mismatches++;
            $display("%0d expected results never arrived", expected_replies.size());
        end

        $display("Sent %0d commands: %0d grants, %0d exhausted replies, %0d releases.",
                 sent_count, grants, exhausted_replies, releases);
        $display("Checked %0d results; peak in-use count %0d, collect flag ended at %b.",
                 replies_checked, peak_in_use, collect_flag);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatching results", mismatches);
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Timed out waiting for the allocator");
        $display("== FAIL ==");
        $finish;
    end

endmodule
